### rtl/tga_pkg.sv
// ----------------------------------------------------------------------------
// tga_pkg
// Shared types and constants of the run-length image pixel decoder.
// ----------------------------------------------------------------------------
package tga_pkg;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_FMT   = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;

    localparam logic [7:0] TYPE_RAW = 8'd2;
    localparam logic [7:0] TYPE_RLE = 8'd10;

    localparam logic [7:0] DEPTH_24 = 8'd24;
    localparam logic [7:0] DEPTH_32 = 8'd32;

    // one decoded result as queued between front and back
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  run_length;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        last_pixel;
        logic [1:0]  status;
    } res_t;

endpackage

### rtl/tga_fe.sv
// ----------------------------------------------------------------------------
// tga_fe
// Byte parser: header, skip region, packet headers and pixel assembly.
// ----------------------------------------------------------------------------
module tga_fe (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          byte_valid,
    input  logic [7:0]    byte_data,
    output logic          res_push,
    output tga_pkg::res_t res_data
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_SKIP   = 3'd1;
    localparam logic [2:0] PH_PACKET = 3'd2;
    localparam logic [2:0] PH_PIXEL  = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;
    localparam logic [2:0] PH_ERROR  = 3'd5;

    localparam logic [4:0] HDR_ID     = 5'd0;
    localparam logic [4:0] HDR_TYPE   = 5'd2;
    localparam logic [4:0] HDR_PAL_LO = 5'd5;
    localparam logic [4:0] HDR_PAL_HI = 5'd6;
    localparam logic [4:0] HDR_W_LO   = 5'd12;
    localparam logic [4:0] HDR_W_HI   = 5'd13;
    localparam logic [4:0] HDR_H_LO   = 5'd14;
    localparam logic [4:0] HDR_H_HI   = 5'd15;
    localparam logic [4:0] HDR_DEPTH  = 5'd16;
    localparam logic [4:0] HDR_LAST   = 5'd17;

    logic [2:0]  phase_reg, phase_next;
    logic [4:0]  hidx_reg, hidx_next;
    logic [7:0]  id_len_reg, id_len_next;
    logic [15:0] pal_len_reg, pal_len_next;
    logic [7:0]  img_type_reg, img_type_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [7:0]  depth_reg, depth_next;
    logic        is32_reg, is32_next;
    logic [16:0] skip_reg, skip_next;
    logic [31:0] pix_rem_reg, pix_rem_next;
    logic        rep_reg, rep_next;
    logic [7:0]  left_reg, left_next;
    logic [1:0]  pbi_reg, pbi_next;
    logic [23:0] pbytes_reg, pbytes_next;

    logic        is_rle;
    logic        fmt_ok;
    logic [31:0] area;
    logic [23:0] assembled;
    logic        more_bytes;
    logic [7:0]  run;
    logic [1:0]  st;
    logic [31:0] rem_after;
    logic [7:0]  left_after;
    logic [2:0]  data_phase;

    assign is_rle     = (img_type_reg == tga_pkg::TYPE_RLE);
    assign fmt_ok     = (img_type_reg inside {tga_pkg::TYPE_RAW, tga_pkg::TYPE_RLE}) &&
                        (depth_reg inside {tga_pkg::DEPTH_24, tga_pkg::DEPTH_32});
    assign area       = {16'd0, width_reg} * {16'd0, height_reg};
    assign data_phase = is_rle ? PH_PACKET : PH_PIXEL;
    assign more_bytes = is32_reg ? (pbi_reg != 2'd3) : (pbi_reg < 2'd2);

    always_comb begin
        assembled = pbytes_reg;
        case (pbi_reg)
            2'd0:    assembled[7:0]   = byte_data;
            2'd1:    assembled[15:8]  = byte_data;
            2'd2:    assembled[23:16] = byte_data;
            default: assembled = pbytes_reg;
        endcase
    end

    always_comb begin
        phase_next    = phase_reg;
        hidx_next     = hidx_reg;
        id_len_next   = id_len_reg;
        pal_len_next  = pal_len_reg;
        img_type_next = img_type_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        depth_next    = depth_reg;
        is32_next     = is32_reg;
        skip_next     = skip_reg;
        pix_rem_next  = pix_rem_reg;
        rep_next      = rep_reg;
        left_next     = left_reg;
        pbi_next      = pbi_reg;
        pbytes_next   = pbytes_reg;
        run           = 8'd1;
        st            = tga_pkg::ST_OK;
        rem_after     = pix_rem_reg;
        left_after    = left_reg;
        res_push      = 1'b0;
        res_data              = '0;
        res_data.image_width  = width_reg;
        res_data.image_height = height_reg;

        if (byte_valid) begin
            case (phase_reg)
                PH_HEADER: begin
                    case (hidx_reg)
                        HDR_ID:     id_len_next         = byte_data;
                        HDR_TYPE:   img_type_next       = byte_data;
                        HDR_PAL_LO: pal_len_next[7:0]   = byte_data;
                        HDR_PAL_HI: pal_len_next[15:8]  = byte_data;
                        HDR_W_LO:   width_next[7:0]     = byte_data;
                        HDR_W_HI:   width_next[15:8]    = byte_data;
                        HDR_H_LO:   height_next[7:0]    = byte_data;
                        HDR_H_HI:   height_next[15:8]   = byte_data;
                        HDR_DEPTH:  depth_next          = byte_data;
                        default: ;
                    endcase
                    if (hidx_reg != HDR_LAST) begin
                        hidx_next = hidx_reg + 5'd1;
                    end else begin
                        hidx_next = '0;
                        if (!fmt_ok) begin
                            phase_next      = PH_ERROR;
                            res_push        = 1'b1;
                            res_data.status = tga_pkg::ST_BAD_FMT;
                        end else begin
                            is32_next    = (depth_reg == tga_pkg::DEPTH_32);
                            pix_rem_next = area;
                            pbi_next     = '0;
                            pbytes_next  = '0;
                            if (width_reg == 16'd0 || height_reg == 16'd0) begin
                                phase_next          = PH_DONE;
                                res_push            = 1'b1;
                                res_data.last_pixel = 1'b1;
                            end else begin
                                skip_next = {9'd0, id_len_reg} + {1'b0, pal_len_reg};
                                if (id_len_reg != 8'd0 || pal_len_reg != 16'd0) begin
                                    phase_next = PH_SKIP;
                                end else begin
                                    rep_next   = 1'b0;
                                    left_next  = '0;
                                    phase_next = data_phase;
                                end
                            end
                        end
                    end
                end
                PH_SKIP: begin
                    skip_next = skip_reg - 17'd1;
                    if (skip_reg == 17'd1) begin
                        rep_next   = 1'b0;
                        left_next  = '0;
                        phase_next = data_phase;
                    end
                end
                PH_PACKET: begin
                    rep_next    = byte_data[7];
                    left_next   = {1'b0, byte_data[6:0]} + 8'd1;
                    pbi_next    = '0;
                    pbytes_next = '0;
                    phase_next  = PH_PIXEL;
                end
                PH_PIXEL: begin
                    if (more_bytes) begin
                        pbi_next    = pbi_reg + 2'd1;
                        pbytes_next = assembled;
                    end else begin
                        pbi_next    = '0;
                        pbytes_next = '0;
                        if (is_rle && rep_reg) begin
                            run = left_reg;
                            // cut the run at the image end
                            if ({24'd0, left_reg} > pix_rem_reg) begin
                                run = pix_rem_reg[7:0];
                                st  = tga_pkg::ST_TRUNCATED;
                            end
                            rem_after  = pix_rem_reg - {24'd0, run};
                            left_after = '0;
                            phase_next = (rem_after == 32'd0) ? PH_DONE : PH_PACKET;
                        end else begin
                            run = 8'd1;
                            if (is_rle && pix_rem_reg == 32'd1 && left_reg > 8'd1) begin
                                st = tga_pkg::ST_TRUNCATED;
                            end
                            rem_after = pix_rem_reg - 32'd1;
                            if (is_rle && left_reg != 8'd0) begin
                                left_after = left_reg - 8'd1;
                            end
                            if (rem_after == 32'd0) begin
                                phase_next = PH_DONE;
                            end else if (is_rle && left_after == 8'd0) begin
                                phase_next = PH_PACKET;
                            end else begin
                                phase_next = PH_PIXEL;
                            end
                        end
                        pix_rem_next        = rem_after;
                        left_next           = left_after;
                        res_push            = 1'b1;
                        res_data.blue       = assembled[7:0];
                        res_data.green      = assembled[15:8];
                        res_data.red        = assembled[23:16];
                        res_data.run_length = run;
                        res_data.last_pixel = (rem_after == 32'd0);
                        res_data.status     = st;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            hidx_reg     <= '0;
            id_len_reg   <= '0;
            pal_len_reg  <= '0;
            img_type_reg <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            depth_reg    <= '0;
            is32_reg     <= 1'b0;
            skip_reg     <= '0;
            pix_rem_reg  <= '0;
            rep_reg      <= 1'b0;
            left_reg     <= '0;
            pbi_reg      <= '0;
            pbytes_reg   <= '0;
        end else begin
            phase_reg    <= phase_next;
            hidx_reg     <= hidx_next;
            id_len_reg   <= id_len_next;
            pal_len_reg  <= pal_len_next;
            img_type_reg <= img_type_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            depth_reg    <= depth_next;
            is32_reg     <= is32_next;
            skip_reg     <= skip_next;
            pix_rem_reg  <= pix_rem_next;
            rep_reg      <= rep_next;
            left_reg     <= left_next;
            pbi_reg      <= pbi_next;
            pbytes_reg   <= pbytes_next;
        end
    end

endmodule

### rtl/tga_fifo.sv
// ----------------------------------------------------------------------------
// tga_fifo
// Small result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module tga_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  tga_pkg::res_t push_data,
    input  logic          pop,
    output tga_pkg::res_t pop_data,
    output logic          not_empty,
    output logic          full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    tga_pkg::res_t mem [DEPTH];
    tga_pkg::res_t head_reg;

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          head_valid_reg, head_valid_next;
    logic          do_push, do_pop;
    logic          head_free, mem_has, mem_rd, mem_wr, bypass;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = head_valid_reg;
    assign pop_data  = head_reg;
    assign do_push   = push && !full;
    assign do_pop    = pop && head_valid_reg;

    // oldest item sits in the head register, the array holds the rest
    assign head_free = !head_valid_reg || do_pop;
    assign mem_has   = (count_reg != '0);
    assign mem_rd    = head_free && mem_has;
    // with everything empty the new item goes straight to the head
    assign bypass    = head_free && !mem_has && do_push;
    assign mem_wr    = do_push && !bypass;

    assign head_valid_next = head_free ? (mem_has || do_push) : 1'b1;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (mem_wr) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (mem_rd) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (mem_wr && !mem_rd) begin
            count_next = count_reg + CW'(1);
        end else if (mem_rd && !mem_wr) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (mem_rd) begin
            head_reg <= mem[rd_ptr_reg];
        end else if (bypass) begin
            head_reg <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
            head_valid_reg <= 1'b0;
        end else begin
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            count_reg      <= count_next;
            head_valid_reg <= head_valid_next;
        end
    end

endmodule

### rtl/tga_be.sv
// ----------------------------------------------------------------------------
// tga_be
// Output stage: drains the queue into a registered result stream.
// ----------------------------------------------------------------------------
module tga_be (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    input  tga_pkg::res_t q_data,
    output logic          q_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [71:0]   m_tdata,
    output logic          m_tlast
);

    logic          valid_reg, valid_next;
    tga_pkg::res_t out_reg;

    assign q_pop      = q_valid && (!valid_reg || m_tready);
    assign valid_next = q_pop || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_reg <= q_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = out_reg.last_pixel;
    assign m_tdata  = {6'd0, out_reg.status, out_reg.image_height, out_reg.image_width,
                       out_reg.run_length, out_reg.blue, out_reg.green, out_reg.red};

endmodule

### rtl/tga_rle_pixel_decoder.sv
// a pixel's result passes through the queue's head register and then the output register to m_tdata
// throughput: one file byte per cycle while s_tready is high, and at most one result per byte
// s_tready drops only while the result queue is full
// reset (aresetn low, synchronous) returns the parser to the header and empties the queue
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// Decodes a raw or run-length coded image byte stream into colored pixel runs.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // file_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // red, green, blue, run_length, image_width,
                                   // image_height, status
    output logic        m_tlast    // last_pixel
);

    tga_pkg::res_t fe_res, q_res;
    logic          fe_push, q_valid, q_full, q_pop;

    assign s_tready = !q_full;

    tga_fe u_fe (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (s_tvalid && s_tready),
        .byte_data  (s_tdata),
        .res_push   (fe_push),
        .res_data   (fe_res)
    );

    tga_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fe_push),
        .push_data (fe_res),
        .pop       (q_pop),
        .pop_data  (q_res),
        .not_empty (q_valid),
        .full      (q_full)
    );

    tga_be u_be (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_res),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
